// File: sv/aesb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES S-box package
// Field arithmetic in GF(2^8), the affine transforms of the forward and
// inverse S-box, and the constant table of multiplicative inverses.
// ----------------------------------------------------------------------------
package aesb_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TableDepth = 256;
  localparam logic [ByteW-1:0] PolyLow = 8'h1B;
  localparam logic [ByteW-1:0] FwdAffineConst = 8'h63;
  localparam logic [ByteW-1:0] InvAffineConst = 8'h05;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t byte_table_t [TableDepth];

  function automatic byte_t rotl(input byte_t v, input int unsigned k);
    byte_t r;
    r = v;
    for (int unsigned i = 0; i < k; i++) begin
      r = {r[ByteW-2:0], r[ByteW-1]};
    end
    return r;
  endfunction

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t x;
    acc = '0;
    x = a;
    for (int unsigned i = 0; i < ByteW; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      if (x[ByteW-1]) begin
        x = {x[ByteW-2:0], 1'b0} ^ PolyLow;
      end else begin
        x = {x[ByteW-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // a^254: the inverse for nonzero a, zero for zero
  function automatic byte_t gf_inv(input byte_t a);
    byte_t res;
    byte_t base;
    logic [ByteW-1:0] e;
    res = 8'h01;
    base = a;
    e = 8'd254;
    for (int unsigned i = 0; i < ByteW; i++) begin
      if (e[i]) begin
        res = gf_mul(res, base);
      end
      base = gf_mul(base, base);
    end
    return res;
  endfunction

  function automatic byte_table_t build_inv_table();
    byte_table_t t;
    for (int unsigned i = 0; i < TableDepth; i++) begin
      t[i] = gf_inv(byte_t'(i));
    end
    return t;
  endfunction

  localparam byte_table_t InvTable = build_inv_table();

  function automatic byte_t affine_fwd(input byte_t a);
    return a ^ rotl(a, 1) ^ rotl(a, 2) ^ rotl(a, 3) ^ rotl(a, 4) ^ FwdAffineConst;
  endfunction

  function automatic byte_t affine_inv(input byte_t a);
    return rotl(a, 1) ^ rotl(a, 3) ^ rotl(a, 6) ^ InvAffineConst;
  endfunction

endpackage

// File: sv/aesb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES S-box datapath
// Inverse affine transform, inverse table lookup and forward affine transform,
// selected by the mode bit.
// ----------------------------------------------------------------------------
module aesb_datapath (
  input  logic           inverse_mode,
  input  aesb_pkg::byte_t din,
  output aesb_pkg::byte_t dout
);

  aesb_pkg::byte_t lookup_addr;
  aesb_pkg::byte_t inv_val;

  always_comb begin
    lookup_addr = inverse_mode ? aesb_pkg::affine_inv(din) : din;
    inv_val = aesb_pkg::InvTable[lookup_addr];
    dout = inverse_mode ? inv_val : aesb_pkg::affine_fwd(inv_val);
  end

endmodule

// File: sv/aes_sbox_forward_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES S-box, forward and inverse
// A request enters the input register on acceptance and the result register when
// the stage advances; a stalled out_ready holds it. Throughput: one request per
// cycle unless out_ready stalls, set by the table lookup between the two registers.
// Reset clears both valid flags and sets inverse_mode to 0 (forward S-box).
// ----------------------------------------------------------------------------
module aes_sbox_forward_inverse (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] sbox_out
);

  logic            inverse_mode;
  logic            stage_valid;
  aesb_pkg::byte_t stage_byte;
  aesb_pkg::byte_t result;
  logic            result_valid;
  aesb_pkg::byte_t dp_out;
  logic            stage_advance;

  assign stage_advance = !result_valid || out_ready;
  assign in_ready = !stage_valid || stage_advance;
  assign out_valid = result_valid;
  assign sbox_out = result;

  aesb_datapath u_datapath (
    .inverse_mode (inverse_mode),
    .din          (stage_byte),
    .dout         (dp_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
      stage_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        inverse_mode <= cfg_wdata;
      end
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (stage_advance) begin
        result_valid <= stage_valid;
      end
    end
  end

  // hold payload unless the stage advances
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= in_byte;
    end
    if (stage_advance && stage_valid) begin
      result <= dp_out;
    end
  end

endmodule
